// ===== src/fpa_pkg.sv =====
// Types and constants for the Q32.32 fixed-point ALU.
// No dependencies; used by fpa_cell and fixed_point_alu_q32_32.
package fpa_pkg;

  localparam int unsigned OpW = 3;
  localparam int unsigned DataW = 64;
  localparam int unsigned WideW = 2 * DataW;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_REM  = 3'd4,
    OP_ITOF = 3'd5
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    divide_by_zero;
  } out_item_t;

  // Work word handed from cell to cell.
  // x: dividend / quotient shift word, or product accumulator, or finished value
  // r: partial remainder, or multiplier bits; d: divisor or multiplicand
  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic             neg;
    logic             dz;
    logic [WideW-1:0] x;
    logic [DataW-1:0] r;
    logic [DataW-1:0] d;
  } work_t;

endpackage

// ===== src/fpa_cell.sv =====
// One pipeline cell: a restoring divide step or a shift-add multiply step.
// Depends on fpa_pkg.
module fpa_cell import fpa_pkg::*; #(
  parameter bit MulStep = 1'b1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  work_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output work_t data_o
);

  logic          valid_q;
  work_t         data_q;
  work_t         data_d;
  logic [DataW:0] rr;
  logic [DataW:0] diff;

  assign ready_o = !valid_q || ready_i;
  assign rr      = {data_i.r, data_i.x[WideW-1]};
  assign diff    = rr - {1'b0, data_i.d};

  always_comb begin
    data_d = data_i;
    case (data_i.opcode)
      OP_MUL: begin
        if (MulStep) begin
          data_d.x = (data_i.x << 1)
                   + (data_i.r[DataW-1] ? {{DataW{1'b0}}, data_i.d} : {WideW{1'b0}});
          data_d.r = data_i.r << 1;
        end
      end
      OP_DIV, OP_REM: begin
        data_d.x = {data_i.x[WideW-2:0], 1'b0};
        if (!diff[DataW]) begin
          data_d.r    = diff[DataW-1:0];
          data_d.x[0] = 1'b1;
        end else begin
          data_d.r = rr[DataW-1:0];
        end
      end
      default: begin
        data_d = data_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/fixed_point_alu_q32_32.sv =====
// Top level of the signed Q32.32 fixed-point ALU.
// Depends on fpa_pkg and fpa_cell.
//
// Usage:
//  - Input channel in_valid_i / in_ready_o carries one transaction per item:
//    opcode, operand_a, operand_b (in_item_t).
//  - Output channel out_valid_o / out_ready_i returns result and the
//    divide_by_zero flag (out_item_t), one per input, in order.
//  - Pipeline: one prep register (magnitudes, shifted dividend, simple ops),
//    a chain of 2*64 identical cells, then the output register.
//    Each cell does one restoring divide step (one quotient bit); the first
//    64 cells also do one shift-add multiply step (one multiplier bit).
//  - Throughput: one transaction per cycle while the output is not stalled; the cell chain sets the latency.
//  - Each stage holds while the next is full and stalled, and empty stages
//    fill up, so the block keeps accepting while the output waits until every stage is full.
//  - Reset clears all valid bits; payload registers are not reset.
module fixed_point_alu_q32_32 import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned NumCells = WideW;

  logic [NumCells:0] v;
  logic [NumCells:0] rdy;
  work_t             w [NumCells+1];

  // ---- prep stage --------------------------------------------------------
  logic             prep_valid_q;
  work_t            prep_q;
  work_t            prep_d;
  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic [DataW-1:0] ma;
  logic [DataW-1:0] mb;
  logic [DataW-1:0] itof;

  assign a    = in_data_i.operand_a;
  assign b    = in_data_i.operand_b;
  assign ma   = a[DataW-1] ? (~a + 1'b1) : a;
  assign mb   = b[DataW-1] ? (~b + 1'b1) : b;
  assign itof = {{(DataW/2){a[DataW/2-1]}}, a[DataW/2-1:0]} << FRAC_BITS;

  always_comb begin
    prep_d        = '0;
    prep_d.opcode = in_data_i.opcode;
    case (in_data_i.opcode)
      OP_ADD:  prep_d.x = {{DataW{1'b0}}, a + b};
      OP_SUB:  prep_d.x = {{DataW{1'b0}}, a - b};
      OP_MUL: begin
        prep_d.neg = a[DataW-1] ^ b[DataW-1];
        prep_d.r   = mb;
        prep_d.d   = ma;
      end
      OP_DIV: begin
        prep_d.dz  = (b == '0);
        prep_d.neg = a[DataW-1] ^ b[DataW-1];
        prep_d.x   = {{DataW{1'b0}}, ma} << FRAC_BITS;
        prep_d.d   = mb;
      end
      OP_REM: begin
        prep_d.dz  = (b == '0);
        prep_d.neg = a[DataW-1];
        prep_d.x   = {{DataW{1'b0}}, ma};
        prep_d.d   = mb;
      end
      OP_ITOF: prep_d.x = {{DataW{1'b0}}, itof};
      default: prep_d.x = '0;
    endcase
  end

  assign in_ready_o = !prep_valid_q || rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      prep_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prep_q <= prep_d;
    end
  end

  assign v[0] = prep_valid_q;
  assign w[0] = prep_q;

  // ---- cell chain --------------------------------------------------------
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fpa_cell #(
      .MulStep(i < DataW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v[i]),
      .ready_o(rdy[i]),
      .data_i (w[i]),
      .valid_o(v[i+1]),
      .ready_i(rdy[i+1]),
      .data_o (w[i+1])
    );
  end

  // ---- finish and output register ----------------------------------------
  work_t            fin;
  logic [WideW-1:0] prod;
  logic [WideW-1:0] prod_sh;
  logic [DataW-1:0] q;
  logic [DataW-1:0] res_d;
  logic             out_valid_q;
  out_item_t        out_q;

  assign fin     = w[NumCells];
  assign prod    = fin.neg ? (~fin.x + 1'b1) : fin.x;
  assign prod_sh = $signed(prod) >>> FRAC_BITS;
  assign q       = fin.x[DataW-1:0];

  always_comb begin
    case (fin.opcode)
      OP_MUL:  res_d = prod_sh[DataW-1:0];
      OP_DIV:  res_d = fin.dz ? '0 : (fin.neg ? (~q + 1'b1) : q);
      OP_REM:  res_d = fin.dz ? '0 : (fin.neg ? (~fin.r + 1'b1) : fin.r);
      default: res_d = q;
    endcase
  end

  assign rdy[NumCells] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[NumCells]) begin
      out_valid_q <= v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NumCells] && v[NumCells]) begin
      out_q.result         <= res_d;
      out_q.divide_by_zero <= fin.dz;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
